/* sv/bfp_pkg.sv */
// Package: frame constants, result type and message id lookup for the frame parser.
`timescale 1ns / 1ps

package bfp_pkg;

  localparam logic [7:0] SYNC0_BYTE = 8'hA0;
  localparam logic [7:0] SYNC1_BYTE = 8'hA1;
  localparam logic [7:0] END0_BYTE  = 8'h0D;
  localparam logic [7:0] END1_BYTE  = 8'h0A;
  localparam logic [7:0] SUBID_LO   = 8'h62;
  localparam logic [7:0] SUBID_HI   = 8'h65;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;
  localparam logic [1:0] STATUS_CSUM_BAD = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [1:0]  status_code;
    logic [15:0] message_id;
    logic [15:0] frame_length;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic        frame_last;
  } res_t;

  function automatic logic id_known(input logic [15:0] id);
    logic hit;
    begin
      case (id)
        16'h6280, 16'h6281, 16'h6380, 16'h6480, 16'h6481, 16'h6483,
        16'h648B, 16'h648C, 16'h648E, 16'h6580, 16'h0080, 16'h0081,
        16'h0083, 16'h0084, 16'h0086, 16'h0087, 16'h0093, 16'h00A8,
        16'h00AE, 16'h00AF, 16'h00B0, 16'h00B1, 16'h00B4, 16'h00B9,
        16'h00BB, 16'hCF01, 16'h00DC, 16'h00DD, 16'h00DE, 16'h00DF,
        16'h00E0: hit = 1'b1;
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

endpackage

/* sv/bfp_parser.sv */
// Frame state tracker: follows sync, length, payload, checksum and end bytes.
`timescale 1ns / 1ps

module bfp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  input  logic          restart,
  output logic          res_valid,
  output bfp_pkg::res_t res
);
  import bfp_pkg::*;

  localparam logic [2:0] PH_SYNC0 = 3'd0;
  localparam logic [2:0] PH_SYNC1 = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CSUM  = 3'd5;
  localparam logic [2:0] PH_END0  = 3'd6;
  localparam logic [2:0] PH_END1  = 3'd7;

  logic [2:0]  phase_r, phase_nxt, phase_cur;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_inc;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] id_r, id_nxt, id_taken;
  logic        ok_r, ok_nxt, ok_end;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] len_full;
  logic        sub_id;

  assign phase_cur = restart ? PH_SYNC0 : phase_r;
  assign count_inc = count_r + 16'd1;
  assign len_full  = {length_r[15:8], rx_byte};
  assign sub_id    = (id_r[15:8] == 8'h00) && (id_r[7:0] >= SUBID_LO) && (id_r[7:0] <= SUBID_HI);
  assign ok_end    = ok_r && (rx_byte == END1_BYTE);

  always_comb begin
    if (count_r == 16'd0) begin
      id_taken = {8'h00, rx_byte};
    end else if (count_r == 16'd1 && sub_id) begin
      id_taken = {id_r[7:0], rx_byte};
    end else begin
      id_taken = id_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_cur;
    length_nxt = length_r;
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    id_nxt     = id_r;
    ok_nxt     = ok_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res        = '0;
    case (phase_cur)
      PH_SYNC0: begin
        length_nxt = '0;
        count_nxt  = '0;
        xor_nxt    = '0;
        id_nxt     = '0;
        sum_nxt    = '0;
        ok_nxt     = (rx_byte == SYNC0_BYTE);
        phase_nxt  = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (rx_byte != SYNC1_BYTE) begin
          ok_nxt = 1'b0;
        end
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        length_nxt = {rx_byte, 8'h00};
        phase_nxt  = PH_LENLO;
      end
      PH_LENLO: begin
        length_nxt = len_full;
        if (len_full == 16'd0) begin
          ok_nxt    = 1'b0;
          phase_nxt = PH_CSUM;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        id_nxt           = id_taken;
        xor_nxt          = xor_r ^ rx_byte;
        count_nxt        = count_inc;
        res_valid        = 1'b1;
        res.result_kind  = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.byte_index   = count_r;
        if (count_inc == length_r) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        id_nxt    = id_taken;
        sum_nxt   = rx_byte;
        phase_nxt = PH_END0;
      end
      PH_END0: begin
        if (rx_byte != END0_BYTE) begin
          ok_nxt = 1'b0;
        end
        phase_nxt = PH_END1;
      end
      PH_END1: begin
        ok_nxt           = ok_end;
        res_valid        = 1'b1;
        res.result_kind  = KIND_STATUS;
        res.message_id   = id_r;
        res.frame_length = length_r;
        res.computed_sum = xor_r;
        res.received_sum = sum_r;
        res.frame_last   = 1'b1;
        if (!ok_end) begin
          res.status_code = STATUS_INVALID;
        end else if (!id_known(id_r)) begin
          res.status_code = STATUS_UNKNOWN;
        end else if (xor_r != sum_r) begin
          res.status_code = STATUS_CSUM_BAD;
        end else begin
          res.status_code = STATUS_OK;
        end
        phase_nxt = PH_SYNC0;
      end
      default: begin
        phase_nxt = PH_SYNC0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC0;
      length_r <= '0;
      count_r  <= '0;
      xor_r    <= '0;
      id_r     <= '0;
      ok_r     <= 1'b1;
      sum_r    <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      xor_r    <= xor_nxt;
      id_r     <= id_nxt;
      ok_r     <= ok_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

/* sv/bfp_out_buf.sv */
// Result register with skid stage between the parser and the result channel.
`timescale 1ns / 1ps

module bfp_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bfp_pkg::res_t push_data,
  output logic          space_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output bfp_pkg::res_t out_data
);
  import bfp_pkg::*;

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_d_r, skid_d_r;
  logic pop, slot_free;

  assign pop       = out_v_r && out_ready;
  assign slot_free = !out_v_r || pop;
  assign space_ok  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    if (slot_free) begin
      out_v_nxt  = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt  = out_v_r;
      skid_v_nxt = skid_v_r || push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule

/* sv/binary_frame_parser_top.sv */
// Top level of the sync/length/XOR-checksum byte stream frame parser.
`timescale 1ns / 1ps

// Takes one received byte per clock transaction and emits every payload byte as it
// arrives, plus one status transaction on the last end byte of each frame (ok,
// invalid framing, unknown id or checksum mismatch). A byte is accepted in every
// cycle while the two-entry output stage has its skid slot free; each result is
// registered there (in the skid slot while out_ stalls). Frame boundaries follow
// the length field; in_restart forces the byte to be taken as the first sync byte.
module binary_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_byte_index,
  output logic [1:0]  out_status_code,
  output logic [15:0] out_message_id,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic        out_frame_last
);
  import bfp_pkg::*;

  logic in_fire;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign in_fire = in_valid && in_ready;

  bfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .restart   (in_restart),
    .res_valid (res_valid),
    .res       (res)
  );

  bfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_data (res),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_result_kind  = out_data.result_kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_byte_index   = out_data.byte_index;
  assign out_status_code  = out_data.status_code;
  assign out_message_id   = out_data.message_id;
  assign out_frame_length = out_data.frame_length;
  assign out_computed_sum = out_data.computed_sum;
  assign out_received_sum = out_data.received_sum;
  assign out_frame_last   = out_data.frame_last;

endmodule

/* tb/frame_parse_checker.sv */
// Checker: predicts the frame parser's results from accepted bytes and compares them.
`timescale 1ns / 1ps

module frame_parse_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [15:0] out_byte_index,
  input  logic [1:0]  out_status_code,
  input  logic [15:0] out_message_id,
  input  logic [15:0] out_frame_length,
  input  logic [7:0]  out_computed_sum,
  input  logic [7:0]  out_received_sum,
  input  logic        out_frame_last,
  output int          mismatch_count,
  output int          pending_count
);
  import bfp_pkg::*;

  typedef enum logic [2:0] {
    SEEK_SYNC0, SEEK_SYNC1, READ_LEN_HI, READ_LEN_LO,
    READ_PAYLOAD, READ_CSUM, READ_END0, READ_END1
  } parse_phase_t;

  parse_phase_t phase_q;
  logic [15:0]  len_q;
  logic [15:0]  count_q;
  logic [15:0]  id_q;
  logic [7:0]   xor_q;
  logic [7:0]   csum_q;
  logic         framing_ok_q;
  res_t         results_due[$];

  function automatic logic id_in_table(input logic [15:0] id);
    logic hit;
    hit = 1'b0;
    case (id[15:8])
      8'h62: hit = (id[7:0] == 8'h80) || (id[7:0] == 8'h81);
      8'h63, 8'h65: hit = (id[7:0] == 8'h80);
      8'h64: begin
        case (id[7:0])
          8'h80, 8'h81, 8'h83, 8'h8B, 8'h8C, 8'h8E: hit = 1'b1;
          default: hit = 1'b0;
        endcase
      end
      8'hCF: hit = (id[7:0] == 8'h01);
      8'h00: begin
        case (id[7:0])
          8'h80, 8'h81, 8'h83, 8'h84, 8'h86, 8'h87, 8'h93, 8'hA8, 8'hAE, 8'hAF,
          8'hB0, 8'hB1, 8'hB4, 8'hB9, 8'hBB, 8'hDC, 8'hDD, 8'hDE, 8'hDF,
          8'hE0: hit = 1'b1;
          default: hit = 1'b0;
        endcase
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Latch the id at position 0 and, after ids 0x62..0x65, the sub-id at position 1.
  task automatic note_id(input logic [7:0] b);
    if (count_q == 16'd0) begin
      id_q = {8'h00, b};
    end else if (count_q == 16'd1 && id_q[15:8] == 8'h00 &&
                 id_q[7:0] >= SUBID_LO && id_q[7:0] <= SUBID_HI) begin
      id_q = {id_q[7:0], b};
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic rs);
    res_t r;
    r = '0;
    if (rs) phase_q = SEEK_SYNC0;
    case (phase_q)
      SEEK_SYNC0: begin
        len_q        = '0;
        count_q      = '0;
        xor_q        = '0;
        id_q         = '0;
        csum_q       = '0;
        framing_ok_q = (b == SYNC0_BYTE);
        phase_q      = SEEK_SYNC1;
      end
      SEEK_SYNC1: begin
        if (b != SYNC1_BYTE) framing_ok_q = 1'b0;
        phase_q = READ_LEN_HI;
      end
      READ_LEN_HI: begin
        len_q   = {b, 8'h00};
        phase_q = READ_LEN_LO;
      end
      READ_LEN_LO: begin
        len_q[7:0] = b;
        if (len_q == 16'd0) begin
          framing_ok_q = 1'b0;
          phase_q      = READ_CSUM;
        end else begin
          phase_q = READ_PAYLOAD;
        end
      end
      READ_PAYLOAD: begin
        note_id(b);
        xor_q          = xor_q ^ b;
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index   = count_q;
        results_due.push_back(r);
        count_q = count_q + 16'd1;
        if (count_q == len_q) phase_q = READ_CSUM;
      end
      READ_CSUM: begin
        note_id(b);
        csum_q  = b;
        phase_q = READ_END0;
      end
      READ_END0: begin
        if (b != END0_BYTE) framing_ok_q = 1'b0;
        phase_q = READ_END1;
      end
      default: begin
        if (b != END1_BYTE) framing_ok_q = 1'b0;
        r.result_kind = KIND_STATUS;
        if (!framing_ok_q)           r.status_code = STATUS_INVALID;
        else if (!id_in_table(id_q)) r.status_code = STATUS_UNKNOWN;
        else if (xor_q != csum_q)    r.status_code = STATUS_CSUM_BAD;
        else                         r.status_code = STATUS_OK;
        r.message_id   = id_q;
        r.frame_length = len_q;
        r.computed_sum = xor_q;
        r.received_sum = csum_q;
        r.frame_last   = 1'b1;
        results_due.push_back(r);
        phase_q = SEEK_SYNC0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t seen;
    res_t want;
    if (!rst_n) begin
      phase_q        = SEEK_SYNC0;
      len_q          = '0;
      count_q        = '0;
      id_q           = '0;
      xor_q          = '0;
      csum_q         = '0;
      framing_ok_q   = 1'b1;
      mismatch_count = 0;
      results_due.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_rx_byte, in_restart);
      if (out_valid && out_ready) begin
        seen = {out_result_kind, out_payload_byte, out_byte_index, out_status_code,
                out_message_id, out_frame_length, out_computed_sum, out_received_sum,
                out_frame_last};
        if (results_due.size() == 0) begin
          $error("result_kind: expected no transaction, got 0x%0h", seen.result_kind);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(seen.result_kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(seen.payload_byte));
          check_field("byte_index", want.byte_index, seen.byte_index);
          check_field("status_code", 16'(want.status_code), 16'(seen.status_code));
          check_field("message_id", want.message_id, seen.message_id);
          check_field("frame_length", want.frame_length, seen.frame_length);
          check_field("computed_sum", 16'(want.computed_sum), 16'(seen.computed_sum));
          check_field("received_sum", 16'(want.received_sum), 16'(seen.received_sum));
          check_field("frame_last", 16'(want.frame_last), 16'(seen.frame_last));
        end
      end
    end
    pending_count = results_due.size();
  end

endmodule

/* tb/tb_binary_frame_parser_top.sv */
// Testbench top: byte stream stimulus, receiver back-pressure and verdict for the frame parser.
`timescale 1ns / 1ps

module tb_binary_frame_parser_top;
  import bfp_pkg::*;

  localparam int RX_HOLD_CYCLES = 200;
  localparam int STALL_LIMIT    = 4000;
  localparam int PHASE_BYTES    = 265;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        in_restart;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_index;
  logic [1:0]  out_status_code;
  logic [15:0] out_message_id;
  logic [15:0] out_frame_length;
  logic [7:0]  out_computed_sum;
  logic [7:0]  out_received_sum;
  logic        out_frame_last;
  int          mismatch_count;
  int          pending_count;

  int          send_idle_pct;
  int          ready_stall_pct;
  int          hold_requests;
  logic [8:0]  stream_q[$];
  logic        resync_next;

  binary_frame_parser_top uut (.*);

  frame_parse_checker frame_checker (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [7:0] one_bit();
    return 8'h01 << $urandom_range(7);
  endfunction

  function automatic logic [15:0] pick_id();
    logic [15:0] id;
    case ($urandom_range(9))
      0: id = 16'h0080;
      1: id = 16'h00E0;
      2: id = 16'h6280;
      3: id = 16'h648E;
      4: id = 16'h6580;
      5: id = 16'h00DD;
      6: id = {8'($urandom_range(8'h62, 8'h65)), 8'h80};
      7: id = 16'hCF01;
      default: id = {8'h00, 8'($urandom_range(255))};
    endcase
    return id;
  endfunction

  task automatic push_stream(input logic [7:0] b, input logic rs);
    stream_q.push_back({rs, b});
  endtask

  task automatic queue_frame(input logic [15:0] id, input int len, input logic [4:0] flaws);
    logic [7:0]  sum;
    logic [7:0]  data;
    logic [15:0] len16;
    int          i;
    sum   = 8'h00;
    len16 = 16'(len);
    push_stream(flaws[0] ? SYNC0_BYTE ^ one_bit() : SYNC0_BYTE,
                resync_next || ($urandom_range(3) == 0));
    push_stream(flaws[1] ? SYNC1_BYTE ^ one_bit() : SYNC1_BYTE, 1'b0);
    push_stream(len16[15:8], 1'b0);
    push_stream(len16[7:0], 1'b0);
    for (i = 0; i < len; i++) begin
      if (i == 0)                       data = (id[15:8] != 8'h00) ? id[15:8] : id[7:0];
      else if (i == 1 && id[15:8] != 0) data = id[7:0];
      else                              data = 8'($urandom_range(255));
      sum = sum ^ data;
      push_stream(data, 1'b0);
    end
    push_stream(flaws[2] ? sum ^ one_bit() : sum, 1'b0);
    push_stream(flaws[3] ? END0_BYTE ^ one_bit() : END0_BYTE, 1'b0);
    push_stream(flaws[4] ? END1_BYTE ^ one_bit() : END1_BYTE, 1'b0);
    resync_next = 1'b0;
  endtask

  // Start a frame, cut it short and force a restart on what follows.
  task automatic queue_aborted_frame(input logic [15:0] len16, input int body);
    int i;
    push_stream(SYNC0_BYTE, resync_next || ($urandom_range(1) == 0));
    push_stream(SYNC1_BYTE, 1'b0);
    push_stream(len16[15:8], 1'b0);
    push_stream(len16[7:0], 1'b0);
    for (i = 0; i < body; i++) push_stream(8'($urandom_range(255)), 1'b0);
    resync_next = 1'b1;
  endtask

  task automatic queue_random_event();
    int         sel;
    int         len;
    int         i;
    logic [4:0] flaws;
    sel = $urandom_range(99);
    case ($urandom_range(7))
      0:       flaws = 5'b00001 << $urandom_range(4);
      1:       flaws = 5'($urandom_range(31));
      default: flaws = 5'b00000;
    endcase
    if (sel < 70) begin
      if ($urandom_range(59) == 0)     len = 300;
      else if ($urandom_range(4) == 0) len = $urandom_range(13, 40);
      else                             len = $urandom_range(1, 12);
      queue_frame(pick_id(), len, flaws);
    end else if (sel < 78) begin
      queue_frame(pick_id(), 0, flaws);
    end else if (sel < 89) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++)
        push_stream(8'($urandom_range(255)), $urandom_range(7) == 0);
      resync_next = 1'b1;
    end else begin
      queue_aborted_frame(($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom_range(65535)),
                          $urandom_range(5));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic drive_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic play_stream();
    logic [8:0] entry;
    while (stream_q.size() > 0) begin
      entry = stream_q.pop_front();
      drive_byte(entry[7:0], entry[8]);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  initial begin : receiver
    int holds_served;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase_idx;
    int sent;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_rx_byte      = 8'h00;
    in_restart      = 1'b0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    hold_requests   = 0;
    resync_next     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_frame(16'h0080, 1, 5'b00000);
    queue_frame(16'h0000, 0, 5'b00000);
    queue_frame(16'h0062, 1, 5'b00000);
    queue_frame(16'hCF01, 2, 5'b00000);
    queue_frame(16'h00E0, 1, 5'b00100);
    queue_frame(16'h00DD, 1, 5'b11011);
    queue_aborted_frame(16'hFFFF, 2);
    queue_frame(16'h00FF, 1, 5'b00000);
    play_stream();
    drain_results();

    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 52; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 52; end
        default: begin send_idle_pct = 21; ready_stall_pct = 21; end
      endcase
      // Hold the receiver off while bytes keep coming.
      if (phase_idx == 0) hold_requests++;
      resync_next = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        queue_random_event();
        sent += stream_q.size();
        play_stream();
      end
      drain_results();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
sv/bfp_pkg.sv
sv/bfp_parser.sv
sv/bfp_out_buf.sv
sv/binary_frame_parser_top.sv
tb/frame_parse_checker.sv
tb/tb_binary_frame_parser_top.sv
